// ----- hdl/keyframe_linear_reducer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the keyframe reducer RTL
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_REDUCER_ASSERT_SVH
`define KEYFRAME_LINEAR_REDUCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define KLR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define KLR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/klr_pkg.sv -----
// ----------------------------------------------------------------------------
// klr_pkg
// Types, codes and widths of the keyframe linear reducer.
// ----------------------------------------------------------------------------
package klr_pkg;

    // Item widths
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned TOL_W      = 16;
    localparam int unsigned NUM_COMP   = 4;
    localparam int unsigned COMP_IDX_W = 2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_TOL = 1'b1;
    localparam logic [TOL_W-1:0]     TOL_RESET     = 16'd1;

    // Divider sizes: 49-bit magnitude of (low - middle) * 2^16 over a
    // 33-bit magnitude of (low - new); quotient kept to 33 bits
    localparam int unsigned DEN_W      = VAL_W + 1;
    localparam int unsigned DIVIDEND_W = DEN_W + 16;
    localparam int unsigned DIV_STEPS  = DEN_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int unsigned HIGH_W     = DIVIDEND_W - DIV_STEPS;

    // Ratio constants, Q16.16
    localparam logic [VAL_W-1:0] RATIO_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] RATIO_MIN = 32'h8000_0000;
    localparam logic [VAL_W+1:0] HALF_Q16  = 34'h0_0000_8000;

    typedef struct packed {
        logic                    first_sample;
        logic        [VAL_W-1:0] sample_time;
        logic signed [VAL_W-1:0] comp_x;
        logic signed [VAL_W-1:0] comp_y;
        logic signed [VAL_W-1:0] comp_z;
        logic signed [VAL_W-1:0] comp_w;
    } t_in;

    typedef struct packed {
        logic        [VAL_W-1:0] key_time;
        logic signed [VAL_W-1:0] key_x;
        logic signed [VAL_W-1:0] key_y;
        logic signed [VAL_W-1:0] key_z;
        logic signed [VAL_W-1:0] key_w;
    } t_out;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_div_stat;

    typedef enum logic [1:0] {
        PH_STOPPED    = 2'd0,
        PH_HAVE_FIRST = 2'd1,
        PH_RUNNING    = 2'd2,
        PH_CONSTANT   = 2'd3
    } t_phase;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEN   = 7'b0000010,
        S_START = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_SAT   = 7'b0010000,
        S_TEST  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

endpackage

// ----- hdl/klr_divider.sv -----
// ----------------------------------------------------------------------------
// klr_divider
// Restoring unsigned divider, one quotient bit per cycle. Flags a quotient
// that does not fit in its 33 bits.
// ----------------------------------------------------------------------------
module klr_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [klr_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [klr_pkg::DEN_W-1:0]          i_divisor,
    output klr_pkg::t_div_stat                 o_stat,
    output logic [klr_pkg::DIV_STEPS-1:0]      o_quotient
);

    logic [klr_pkg::DEN_W-1:0]     r_rem;
    logic [klr_pkg::DIV_STEPS-1:0] r_acc;
    logic [klr_pkg::DEN_W-1:0]     r_den;
    logic [klr_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic                          r_ovf;

    logic [klr_pkg::DEN_W+1:0]     w_diff;
    logic                          w_fits;
    logic [klr_pkg::DEN_W-1:0]     w_start_rem;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_diff = {1'b0, r_rem, r_acc[klr_pkg::DIV_STEPS-1]} - {2'b00, r_den};
    assign w_fits = !w_diff[klr_pkg::DEN_W+1];

    // Dividend bits above the quotient range form the first remainder
    assign w_start_rem = {{(klr_pkg::DEN_W - klr_pkg::HIGH_W){1'b0}},
                          i_dividend[klr_pkg::DIVIDEND_W-1:klr_pkg::DIV_STEPS]};

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= klr_pkg::DIV_CNT_W'(klr_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == klr_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift one quotient bit into the low end per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_start_rem;
            r_acc <= i_dividend[klr_pkg::DIV_STEPS-1:0];
            r_den <= i_divisor;
            r_ovf <= (w_start_rem >= i_divisor);
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[klr_pkg::DEN_W-1:0]
                            : {r_rem[klr_pkg::DEN_W-2:0], r_acc[klr_pkg::DIV_STEPS-1]};
            r_acc <= {r_acc[klr_pkg::DIV_STEPS-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quotient  = r_acc;

endmodule

// ----- hdl/keyframe_linear_reducer.sv -----
// First sample, or a second unlike the first: S_EMIT loads the output register.
// Running sample: S_DEN and S_START per flat component; a divided component
// also takes S_DIV on the shared one-bit-per-cycle divider, S_SAT and S_TEST.
// Throughput: one item at a time; the input is not ready until it finishes.
// Reset (synchronous, active low): track stopped, output empty, tolerances 1.
// ----------------------------------------------------------------------------
// keyframe_linear_reducer
// Drops animation keys that lie on a line through the two previous samples,
// testing the four components in turn on one shared divider.
// ----------------------------------------------------------------------------
`include "keyframe_linear_reducer_assert.svh"

module keyframe_linear_reducer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [klr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [klr_pkg::TOL_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  klr_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output klr_pkg::t_out                     o_out
);

    localparam int unsigned VW = klr_pkg::VAL_W;
    localparam int unsigned CW = klr_pkg::COMP_IDX_W;

    klr_pkg::t_state           r_state, n_state;
    klr_pkg::t_phase           r_phase, n_phase;
    logic [CW-1:0]             r_comp, n_comp;
    logic [klr_pkg::TOL_W-1:0] r_ftol, r_rtol;
    logic                      r_out_vld;
    klr_pkg::t_out             r_out;

    logic [VW-1:0] r_low [klr_pkg::NUM_COMP];
    logic [VW-1:0] r_mid [klr_pkg::NUM_COMP];
    logic [VW-1:0] r_hi  [klr_pkg::NUM_COMP];
    logic [VW-1:0] r_time;

    logic [klr_pkg::DEN_W-1:0]      r_dmag;
    logic [klr_pkg::DIVIDEND_W-1:0] r_dividend;
    logic                           r_neg;
    logic                           r_flat;
    logic [VW-1:0]                  r_ratio;

    logic [VW-1:0] w_in_comp [klr_pkg::NUM_COMP];
    logic          w_in_acc;
    logic          w_same;
    logic          w_load_first, w_load_mid, w_shift, w_emit, w_div_start;
    logic          w_last;

    logic [klr_pkg::DEN_W-1:0] w_den, w_num, w_dmag, w_nmag;
    logic [VW-1:0]             w_lo, w_md, w_hi;

    klr_pkg::t_div_stat             w_div_stat;
    logic [klr_pkg::DIV_STEPS-1:0]  w_quot;
    logic [VW-1:0]                  w_ratio;
    logic [VW+1:0]                  w_rdiff, w_radiff;
    logic                           w_break;

    assign w_in_comp[0] = i_in.comp_x;
    assign w_in_comp[1] = i_in.comp_y;
    assign w_in_comp[2] = i_in.comp_z;
    assign w_in_comp[3] = i_in.comp_w;

    assign o_in_ready = (r_state == klr_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last     = (r_comp == CW'(klr_pkg::NUM_COMP - 1));

    // Second sample equal to the first in all components
    always_comb begin
        w_same = 1'b1;
        for (int p = 0; p < klr_pkg::NUM_COMP; p++) begin
            if (w_in_comp[p] != r_low[p]) begin
                w_same = 1'b0;
            end
        end
    end

    // Operands of the current component: differences and magnitudes
    assign w_lo   = r_low[r_comp];
    assign w_md   = r_mid[r_comp];
    assign w_hi   = r_hi[r_comp];
    assign w_den  = {w_lo[VW-1], w_lo} - {w_hi[VW-1], w_hi};
    assign w_num  = {w_lo[VW-1], w_lo} - {w_md[VW-1], w_md};
    assign w_dmag = w_den[VW] ? (klr_pkg::DEN_W'(0) - w_den) : w_den;
    assign w_nmag = w_num[VW] ? (klr_pkg::DEN_W'(0) - w_num) : w_num;

    // Saturate the signed quotient to Q16.16
    always_comb begin
        if (!r_neg) begin
            w_ratio = (w_div_stat.ovf || (w_quot[VW:VW-1] != 2'b00))
                    ? klr_pkg::RATIO_MAX : w_quot[VW-1:0];
        end else begin
            w_ratio = (w_div_stat.ovf || (w_quot > {1'b0, klr_pkg::RATIO_MIN}))
                    ? klr_pkg::RATIO_MIN : (VW'(0) - w_quot[VW-1:0]);
        end
    end

    // Distance of the ratio from one half against the ratio tolerance
    assign w_rdiff  = {{2{r_ratio[VW-1]}}, r_ratio} - klr_pkg::HALF_Q16;
    assign w_radiff = w_rdiff[VW+1] ? ((VW + 2)'(0) - w_rdiff) : w_rdiff;
    assign w_break  = w_radiff > {{(VW + 2 - klr_pkg::TOL_W){1'b0}}, r_rtol};

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_comp       = r_comp;
        w_load_first = 1'b0;
        w_load_mid   = 1'b0;
        w_shift      = 1'b0;
        w_emit       = 1'b0;
        w_div_start  = 1'b0;
        case (r_state)
            klr_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.first_sample) begin
                        w_load_first = 1'b1;
                        n_phase      = klr_pkg::PH_HAVE_FIRST;
                        n_state      = klr_pkg::S_EMIT;
                    end else begin
                        case (r_phase)
                            klr_pkg::PH_HAVE_FIRST: begin
                                w_load_mid = 1'b1;
                                if (w_same) begin
                                    n_phase = klr_pkg::PH_CONSTANT;
                                end else begin
                                    n_phase = klr_pkg::PH_RUNNING;
                                    n_state = klr_pkg::S_EMIT;
                                end
                            end
                            klr_pkg::PH_RUNNING: begin
                                n_comp  = '0;
                                n_state = klr_pkg::S_DEN;
                            end
                            default: begin
                                n_state = klr_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            klr_pkg::S_DEN: begin
                n_state = klr_pkg::S_START;
            end
            klr_pkg::S_START: begin
                if (r_flat) begin
                    if (w_last) begin
                        w_shift = 1'b1;
                        n_state = klr_pkg::S_IDLE;
                    end else begin
                        n_comp  = r_comp + 1'b1;
                        n_state = klr_pkg::S_DEN;
                    end
                end else begin
                    w_div_start = 1'b1;
                    n_state     = klr_pkg::S_DIV;
                end
            end
            klr_pkg::S_DIV: begin
                if (w_div_stat.done) begin
                    n_state = klr_pkg::S_SAT;
                end
            end
            klr_pkg::S_SAT: begin
                n_state = klr_pkg::S_TEST;
            end
            klr_pkg::S_TEST: begin
                if (w_break) begin
                    w_shift = 1'b1;
                    n_state = klr_pkg::S_EMIT;
                end else if (w_last) begin
                    w_shift = 1'b1;
                    n_state = klr_pkg::S_IDLE;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = klr_pkg::S_DEN;
                end
            end
            klr_pkg::S_EMIT: begin
                if (!r_out_vld || i_out_ready) begin
                    w_emit  = 1'b1;
                    n_state = klr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = klr_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= klr_pkg::S_IDLE;
            r_phase   <= klr_pkg::PH_STOPPED;
            r_comp    <= '0;
            r_out_vld <= 1'b0;
            r_ftol    <= klr_pkg::TOL_RESET;
            r_rtol    <= klr_pkg::TOL_RESET;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_comp  <= n_comp;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    klr_pkg::CFG_FLAT_TOL:  r_ftol <= i_cfg_data;
                    klr_pkg::CFG_RATIO_TOL: r_rtol <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture the item and move the window
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_time <= i_in.sample_time;
        end
        for (int p = 0; p < klr_pkg::NUM_COMP; p++) begin
            if (w_in_acc) begin
                r_hi[p] <= w_in_comp[p];
            end
            if (w_load_first) begin
                r_low[p] <= w_in_comp[p];
                r_mid[p] <= '0;
            end else if (w_load_mid) begin
                r_mid[p] <= w_in_comp[p];
            end else if (w_shift) begin
                r_low[p] <= r_mid[p];
                r_mid[p] <= r_hi[p];
            end
        end
    end

    // Register divider operands, then the saturated ratio
    always_ff @(posedge i_clk) begin
        if (r_state == klr_pkg::S_DEN) begin
            r_dmag     <= w_dmag;
            r_dividend <= {w_nmag, 16'h0000};
            r_neg      <= w_den[VW] ^ w_num[VW];
            r_flat     <= w_dmag <= {{(klr_pkg::DEN_W - klr_pkg::TOL_W){1'b0}}, r_ftol};
        end
        if (r_state == klr_pkg::S_SAT) begin
            r_ratio <= w_ratio;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.key_time <= r_time;
            r_out.key_x    <= r_hi[0];
            r_out.key_y    <= r_hi[1];
            r_out.key_z    <= r_hi[2];
            r_out.key_w    <= r_hi[3];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    klr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_dmag),
        .o_stat     (w_div_stat),
        .o_quotient (w_quot)
    );

    // Checks
    `KLR_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, w_div_start, !w_div_stat.busy)
    `KLR_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_stat.done, r_state == klr_pkg::S_DIV)
    `KLR_ASSERT_NXT(a_run_starts_x, i_clk, i_rst_n, w_in_acc && !i_in.first_sample && r_phase == klr_pkg::PH_RUNNING, r_state == klr_pkg::S_DEN && r_comp == '0)
    `KLR_ASSERT_NXT(a_constant_silent, i_clk, i_rst_n, w_in_acc && !i_in.first_sample && r_phase == klr_pkg::PH_CONSTANT, r_state == klr_pkg::S_IDLE)
    `KLR_ASSERT_NXT(a_emit_loads_out, i_clk, i_rst_n, w_emit, r_out_vld && o_out.key_time == $past(r_time))

endmodule
